[design/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg - shared types for the positional deque
// opcodes, status codes and the command broadcast to the cell row
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int KeyW = 32;

    typedef logic signed [KeyW-1:0] t_key;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_INSERT_AT  = 3'd4,
        OP_REMOVE_AT  = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_POS   = 2'd3
    } t_status;

    // command seen by every cell in the row
    typedef struct packed {
        logic ins;   // open a gap at the target and store key there
        logic rem;   // close the gap at the target
        t_key key;
    } t_cell_cmd;

endpackage

[design/dq_cmd_if.sv]
// ----------------------------------------------------------------------------
// dq_cmd_if - command channel
// valid/ready channel carrying one deque command per beat
// ----------------------------------------------------------------------------
interface dq_cmd_if;
    logic            valid;
    logic            ready;
    dq_pkg::t_opcode opcode;
    dq_pkg::t_key    key_in;
    logic [4:0]      position;

    modport source (output valid, output opcode, output key_in, output position,
                    input ready);
    modport sink   (input valid, input opcode, input key_in, input position,
                    output ready);
endinterface

[design/dq_rsp_if.sv]
// ----------------------------------------------------------------------------
// dq_rsp_if - result channel
// valid/ready channel carrying one result per beat
// ----------------------------------------------------------------------------
interface dq_rsp_if;
    logic            valid;
    logic            ready;
    dq_pkg::t_key    key_out;
    logic            key_valid;
    dq_pkg::t_status status;
    logic [4:0]      occupancy;

    modport source (output valid, output key_out, output key_valid, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input key_out, input key_valid, input status,
                    input occupancy, output ready);
endinterface

[design/deque_with_positional_insert_remove.sv]
// ----------------------------------------------------------------------------
// deque_with_positional_insert_remove - bounded deque with positional access
// row of DEPTH-1 shift cells in logical order, cell 0 is the head
// ----------------------------------------------------------------------------
// usage
//   i_cmd carries one command per beat: push back/front, pop back/front,
//   insert at a position or remove at a position (offset from the head)
//   o_rsp returns exactly one result beat per command: removed key with
//   key_valid, a status code and the occupancy after the command
// timing
//   a command is decoded and applied in the cycle it is accepted; every cell
//   loads its neighbor, the new key or itself at the same clock edge, so the
//   whole row shifts at once and the result is registered at that edge;
//   the result is valid on o_rsp in the cycle after the command beat
//   throughput is one command per cycle while o_rsp drains; the bound is the
//   registered fill count, which the next command reads to decode its target cell
// stall
//   a single result register sits on o_rsp; a new command is taken when that
//   register is empty or is being drained in the same cycle, so a stalled
//   receiver holds back the command side after one pending result
// reset
//   fill count and result valid clear; cell contents are left as they are
//   and are never read before being written
// ----------------------------------------------------------------------------
module deque_with_positional_insert_remove #(
    parameter int DEPTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dq_cmd_if.sink   i_cmd,
    dq_rsp_if.source o_rsp
);
    import dq_pkg::*;

    localparam int CAP = DEPTH - 1;           // cells in the row
    localparam int CW  = $clog2(DEPTH);       // fill count and cell index width
    localparam int PW  = (CW > 5) ? CW : 5;   // width for position compares

    // fill count
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;

    // result register
    logic          r_rsp_valid;
    t_key          r_key_out;
    logic          r_key_valid;
    t_status       r_status;
    logic [4:0]    r_occ;

    // decode
    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    logic [PW-1:0] w_pos_ext;
    logic [PW-1:0] w_fill_ext;
    logic          w_do_ins;
    logic          w_do_rem;
    logic [CW-1:0] w_target;
    t_status       w_status;
    t_cell_cmd     w_cell_cmd;
    logic [31:0]   w_occ_wide;

    // cell row
    t_key          w_key [CAP];
    t_key          w_tap [CAP];
    t_key          w_tap_or;

    // command side opens when the result register is free or draining
    assign i_cmd.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_full     = (r_fill == CW'(CAP));
    assign w_empty    = (r_fill == '0);
    assign w_pos_ext  = PW'(i_cmd.position);
    assign w_fill_ext = PW'(r_fill);

    always_comb begin
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        w_target = '0;
        w_status = ST_OK;
        unique case (i_cmd.opcode) inside
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_AT: begin
                // full wins over a bad position
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (i_cmd.opcode == OP_PUSH_BACK) begin
                    w_do_ins = 1'b1;
                    w_target = r_fill;
                end else if (i_cmd.opcode == OP_PUSH_FRONT) begin
                    w_do_ins = 1'b1;
                end else if (w_pos_ext > w_fill_ext) begin
                    w_status = ST_POS;
                end else begin
                    // position equal to the count appends at the back
                    w_do_ins = 1'b1;
                    w_target = w_pos_ext[CW-1:0];
                end
            end
            OP_POP_BACK, OP_POP_FRONT, OP_REMOVE_AT: begin
                // empty wins over a bad position
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (i_cmd.opcode == OP_POP_BACK) begin
                    w_do_rem = 1'b1;
                    w_target = r_fill - 1'b1;
                end else if (i_cmd.opcode == OP_POP_FRONT) begin
                    w_do_rem = 1'b1;
                end else if (w_pos_ext >= w_fill_ext) begin
                    w_status = ST_POS;
                end else begin
                    w_do_rem = 1'b1;
                    w_target = w_pos_ext[CW-1:0];
                end
            end
            default: begin
                // unused opcodes: no change, ok status
            end
        endcase
    end

    // broadcast to the row only on an accepted beat
    assign w_cell_cmd.ins = w_accept && w_do_ins;
    assign w_cell_cmd.rem = w_accept && w_do_rem;
    assign w_cell_cmd.key = i_cmd.key_in;

    always_comb begin
        n_fill = r_fill;
        if (w_do_ins) begin
            n_fill = r_fill + 1'b1;
        end else if (w_do_rem) begin
            n_fill = r_fill - 1'b1;
        end
    end

    // occupancy is reported modulo 32
    assign w_occ_wide = 32'(n_fill);

    // the row: each cell sees its two neighbors, ends are tied off
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        t_key w_left;
        t_key w_right;
        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_key[g-1];
        end
        if (g == CAP - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_key[g+1];
        end
        dq_cell #(
            .IW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cell_cmd),
            .i_pos   (w_target),
            .i_left  (w_left),
            .i_right (w_right),
            .o_key   (w_key[g]),
            .o_tap   (w_tap[g])
        );
    end

    // only the target cell drives a nonzero tap
    always_comb begin
        w_tap_or = '0;
        for (int i = 0; i < CAP; i++) begin
            w_tap_or = w_tap_or | w_tap[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill      <= n_fill;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with the beat that produced it
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key_out   <= w_do_rem ? w_tap_or : '0;
            r_key_valid <= w_do_rem;
            r_status    <= w_status;
            r_occ       <= w_occ_wide[4:0];
        end
    end

    assign o_rsp.valid     = r_rsp_valid;
    assign o_rsp.key_out   = r_key_out;
    assign o_rsp.key_valid = r_key_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.occupancy = r_occ;

endmodule

[design/dq_cell.sv]
// ----------------------------------------------------------------------------
// dq_cell - one storage cell of the deque row
// holds one key; takes the new key, or its left or right neighbor, on insert or remove
// ----------------------------------------------------------------------------
module dq_cell #(
    parameter int IW  = 5,
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  dq_pkg::t_cell_cmd   i_cmd,
    input  logic [IW-1:0]       i_pos,
    input  dq_pkg::t_key        i_left,
    input  dq_pkg::t_key        i_right,
    output dq_pkg::t_key        o_key,
    output dq_pkg::t_key        o_tap
);
    import dq_pkg::*;

    localparam logic [IW-1:0] MyIdx = IW'(IDX);

    t_key r_key;
    t_key n_key;
    logic w_hit;
    logic w_above;

    assign w_hit   = (i_pos == MyIdx);
    assign w_above = (MyIdx > i_pos);

    always_comb begin
        n_key = r_key;
        if (i_cmd.ins) begin
            if (w_hit) begin
                n_key = i_cmd.key;
            end else if (w_above) begin
                n_key = i_left;
            end
        end else if (i_cmd.rem) begin
            if (w_hit || w_above) begin
                n_key = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;
    // masked key for the or-tree read of the target cell
    assign o_tap = w_hit ? r_key : '0;

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb - self-checking bench for the positional deque
// random and directed command beats on i_cmd, every result beat on o_rsp
// checked field by field against a shadow deque kept in the bench
// ----------------------------------------------------------------------------
module tb;

    import dq_pkg::*;

    localparam int DEPTH       = 32;
    localparam int CAP         = DEPTH - 1;
    localparam int CYCLE_LIMIT = 100000;
    localparam int CALM_START  = 1500;   // no idling on either side in this window
    localparam int CALM_END    = 3000;
    localparam int HOLD_START  = 600;    // long receiver hold, in receiver cycles
    localparam int HOLD_LEN    = 300;
    localparam int RANDOM_CMDS = 930;

    // one command beat as queued for the driver
    typedef struct {
        logic [2:0] op;
        t_key       key;
        logic [4:0] pos;
    } t_cmd_beat;

    // one result beat as the block should return it
    typedef struct {
        t_key       key_out;
        logic       key_valid;
        t_status    status;
        logic [4:0] occupancy;
    } t_deque_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dq_cmd_if cmd_if ();
    dq_rsp_if rsp_if ();

    deque_with_positional_insert_remove #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_rsp  (rsp_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_cmd_beat     cmd_backlog[$];      // beats not yet offered
    t_deque_result pending_results[$];  // predicted results, oldest first
    t_cmd_beat     next_cmd;
    int            mismatch_count = 0;
    int            tb_cycle       = 0;
    int            gen_count      = 0;  // occupancy as seen by the generator

    // shadow copy of the cell row, head at index 0
    t_key row_keys [0:CAP-1];
    int   row_count = 0;

    // ------------------------------------------------------------------------
    // shadow deque: apply one command and return the result it gives
    // ------------------------------------------------------------------------
    function automatic t_deque_result apply_command(logic [2:0] op, t_key key,
                                                    logic [4:0] pos);
        t_deque_result r;
        int            at;
        int            i;
        r.key_out   = '0;
        r.key_valid = 1'b0;
        r.status    = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_AT: begin
                // full is checked before the position
                if (row_count >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    if (op == OP_PUSH_BACK)       at = row_count;
                    else if (op == OP_PUSH_FRONT) at = 0;
                    else                          at = int'(pos);
                    // insert may append at position == occupancy
                    if (at > row_count) begin
                        r.status = ST_POS;
                    end else begin
                        for (i = row_count; i > at; i--) row_keys[i] = row_keys[i-1];
                        row_keys[at] = key;
                        row_count++;
                    end
                end
            end
            OP_POP_BACK, OP_POP_FRONT, OP_REMOVE_AT: begin
                // empty is checked before the position
                if (row_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (op == OP_POP_BACK)       at = row_count - 1;
                    else if (op == OP_POP_FRONT) at = 0;
                    else                         at = int'(pos);
                    if (at >= row_count) begin
                        r.status = ST_POS;
                    end else begin
                        r.key_out   = row_keys[at];
                        r.key_valid = 1'b1;
                        for (i = at; i + 1 < row_count; i++) row_keys[i] = row_keys[i+1];
                        row_count--;
                    end
                end
            end
            default: begin
                // undefined opcodes leave everything as it is
            end
        endcase
        r.occupancy = row_count[4:0];
        return r;
    endfunction

    // queue one beat and track the occupancy it leads to, so that the random
    // part can aim positions at the live range
    task automatic add_cmd(logic [2:0] op, t_key key, logic [4:0] pos);
        t_cmd_beat c;
        c.op  = op;
        c.key = key;
        c.pos = pos;
        cmd_backlog.push_back(c);
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
                if (gen_count < CAP) gen_count++;
            OP_INSERT_AT:
                if (gen_count < CAP && int'(pos) <= gen_count) gen_count++;
            OP_POP_BACK, OP_POP_FRONT:
                if (gen_count > 0) gen_count--;
            OP_REMOVE_AT:
                if (gen_count > 0 && int'(pos) < gen_count) gen_count--;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // driver: offers the next backlog beat, holds it until accepted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid    <= 1'b0;
            cmd_if.opcode   <= OP_PUSH_BACK;
            cmd_if.key_in   <= '0;
            cmd_if.position <= '0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            // slot is free: either nothing offered or the beat just went in
            if (cmd_backlog.size() != 0 &&
                !((tb_cycle < CALM_START || tb_cycle >= CALM_END) &&
                  $urandom_range(0, 99) < 33)) begin
                next_cmd         = cmd_backlog.pop_front();
                cmd_if.valid    <= 1'b1;
                cmd_if.opcode   <= t_opcode'(next_cmd.op);
                cmd_if.key_in   <= next_cmd.key;
                cmd_if.position <= next_cmd.pos;
            end else begin
                cmd_if.valid    <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls plus one long hold counted here, so the single
    // result register fills and the command side backs up
    // ------------------------------------------------------------------------
    int rx_cycle  = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle == HOLD_START) begin
                hold_left    <= HOLD_LEN;
                rsp_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end else if (tb_cycle >= CALM_START && tb_cycle < CALM_END) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= 33);
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on each command beat, checks each result beat
    // ------------------------------------------------------------------------
    t_deque_result got;
    t_deque_result want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                pending_results.push_back(apply_command(cmd_if.opcode, cmd_if.key_in,
                                                        cmd_if.position));
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got.key_out   = rsp_if.key_out;
                got.key_valid = rsp_if.key_valid;
                got.status    = rsp_if.status;
                got.occupancy = rsp_if.occupancy;
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected: key_out %0d status %0d",
                             $time, got.key_out, got.status);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.key_out !== want.key_out) begin
                        $display("%0t: key_out expected %0d actual %0d",
                                 $time, want.key_out, got.key_out);
                        mismatch_count++;
                    end
                    if (got.key_valid !== want.key_valid) begin
                        $display("%0t: key_valid expected %0b actual %0b",
                                 $time, want.key_valid, got.key_valid);
                        mismatch_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.occupancy !== want.occupancy) begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occupancy, got.occupancy);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        tb_cycle <= tb_cycle + 1;
        if (tb_cycle == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    int   phase;       // 0 filling, 1 draining, 2 mixed
    int   phase_left;
    int   roll;
    logic [2:0] op;
    logic [4:0] pos;

    initial begin
        cmd_if.valid    = 1'b0;
        cmd_if.opcode   = OP_PUSH_BACK;
        cmd_if.key_in   = '0;
        cmd_if.position = '0;
        rsp_if.ready    = 1'b0;

        // directed: removals on empty, bad positions, key extremes, odd opcodes
        add_cmd(OP_POP_BACK,   32'sd0, 5'd0);
        add_cmd(OP_POP_FRONT,  32'sd0, 5'd0);
        add_cmd(OP_REMOVE_AT,  32'sd0, 5'd0);
        add_cmd(OP_REMOVE_AT,  32'sd0, 5'd31);
        add_cmd(OP_INSERT_AT,  32'sd7, 5'd1);
        add_cmd(OP_INSERT_AT,  32'sh7fffffff, 5'd0);
        add_cmd(OP_PUSH_BACK,  32'sh80000000, 5'd31);
        add_cmd(OP_PUSH_FRONT, -32'sd1, 5'd0);
        add_cmd(OP_PUSH_BACK,  32'sd0, 5'd0);
        add_cmd(OP_INSERT_AT,  32'sd5, 5'd4);
        add_cmd(OP_INSERT_AT,  32'sh5a5a5a5a, 5'd2);
        add_cmd(OP_REMOVE_AT,  32'sd0, 5'd6);
        add_cmd(OP_REMOVE_AT,  32'sd0, 5'd5);
        add_cmd(OP_REMOVE_AT,  32'sd0, 5'd0);
        add_cmd(3'd6,          32'sh12345678, 5'd3);
        add_cmd(3'd7,          -32'sd1, 5'd31);
        add_cmd(OP_INSERT_AT,  32'sd9, 5'd31);
        add_cmd(OP_REMOVE_AT,  32'sd0, 5'd31);
        add_cmd(OP_POP_BACK,   32'sd0, 5'd0);
        add_cmd(OP_POP_FRONT,  32'sd0, 5'd0);
        add_cmd(OP_POP_FRONT,  32'sd0, 5'd0);

        // random: phases that drive toward full, toward empty, or hover
        phase_left = 0;
        repeat (RANDOM_CMDS) begin
            if (phase_left == 0) begin
                phase      = $urandom_range(0, 2);
                phase_left = $urandom_range(30, 80);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                // noise: any opcode, any position
                op  = 3'($urandom_range(0, 7));
                pos = 5'($urandom_range(0, 31));
            end else begin
                roll = $urandom_range(0, 99);
                if ((phase == 0 && roll < 85) || (phase == 1 && roll < 15) ||
                    (phase == 2 && roll < 50)) begin
                    op = 3'($urandom_range(0, 2) == 0 ? OP_PUSH_BACK :
                            $urandom_range(0, 1) == 0 ? OP_PUSH_FRONT : OP_INSERT_AT);
                    pos = 5'($urandom_range(0, gen_count > CAP - 1 ? CAP - 1 : gen_count));
                end else begin
                    op = 3'($urandom_range(0, 2) == 0 ? OP_POP_BACK :
                            $urandom_range(0, 1) == 0 ? OP_POP_FRONT : OP_REMOVE_AT);
                    pos = 5'(gen_count > 0 ? $urandom_range(0, gen_count - 1) : 0);
                end
            end
            add_cmd(op, t_key'($urandom), pos);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every beat offered and taken, then every result back
        while (cmd_backlog.size() != 0 || cmd_if.valid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        // let the clock run on to catch any stray result beat
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
design/dq_pkg.sv
design/dq_cmd_if.sv
design/dq_rsp_if.sv
design/dq_cell.sv
design/deque_with_positional_insert_remove.sv
test/tb.sv
